FILE: hdl/psx_pkg.sv
// Shared types and constants for the printable string extractor.
package psx_pkg;

  // Field widths
  localparam int unsigned KindW   = 1;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned PosW    = 48;
  localparam int unsigned RunW    = 16;
  localparam int unsigned MinLenW = 16;

  // Packed output data width, rounded up to whole bytes
  localparam int unsigned OutDataW = ((CharW + PosW + 7) / 8) * 8;

  // Printable ASCII range and register reset
  localparam logic [ByteW-1:0]   FirstPrintable = 8'h20;
  localparam logic [ByteW-1:0]   LastPrintable  = 8'h7E;
  localparam logic [MinLenW-1:0] MinLenReset    = 16'd4;
  localparam logic [RunW-1:0]    RunMax         = 16'hFFFF;

  // Input kind codes
  localparam logic [KindW-1:0] KindData = 1'b0;
  localparam logic [KindW-1:0] KindEos  = 1'b1;

  // Default buffer depth (holds depth-1 characters)
  localparam int unsigned BufferDepthDefault = 64;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } psx_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input beat accepted this cycle
    logic load;   // move read character into the output register
  } psx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit_req;  // current input beat ends a run long enough to report
    logic rd_last;   // read pointer sits on the final stored character
    logic out_free;  // output register can take a new beat
  } psx_sts_t;

endpackage

FILE: hdl/psx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psx_ram
  import psx_pkg::*;
#(
  parameter int unsigned WIDTH = CharW,
  parameter int unsigned DEPTH = BufferDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/psx_ctrl.sv
// Controller state machine: accepts input beats and sequences string read-out.
module psx_ctrl
  import psx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  psx_sts_t sts_i,
  output psx_cmd_t cmd_o
);

  psx_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.emit_req) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // RAM read issued; data lands next cycle
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/psx_dp.sv
// Datapath: position and run counters, character buffer and output register.
module psx_dp
  import psx_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MinLenW-1:0] cfg_data_i,
  input  logic [KindW-1:0]   in_kind_i,
  input  logic [ByteW-1:0]   in_byte_i,
  input  psx_cmd_t           cmd_i,
  output psx_sts_t           sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CharW-1:0]   out_char_o,
  output logic [PosW-1:0]    out_offset_o,
  output logic               out_last_o
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);
  localparam logic [RunW-1:0] SlotsRun = RunW'(BUFFER_DEPTH - 1);
  localparam logic [IW-1:0]   SlotsIdx = IW'(BUFFER_DEPTH - 1);

  logic [PosW-1:0]    byte_pos_q;
  logic [RunW-1:0]    run_len_q;
  logic [PosW-1:0]    run_start_q;
  logic [MinLenW-1:0] min_len_q;
  logic [IW-1:0]      rd_idx_q;
  logic [IW-1:0]      last_idx_q;
  logic               out_valid_q;
  logic [CharW-1:0]   out_char_q;
  logic [PosW-1:0]    out_offset_q;
  logic               out_last_q;

  logic             is_eos;
  logic             is_print;
  logic             ends_run;
  logic             run_ok;
  logic             store_we;
  logic [IW-1:0]    emit_cnt;
  logic [CharW-1:0] rd_char;

  // Classify the incoming beat
  assign is_eos   = (in_kind_i == KindEos);
  assign is_print = (in_byte_i >= FirstPrintable) && (in_byte_i <= LastPrintable);
  assign ends_run = is_eos || !is_print;
  // zero min_len behaves as one
  assign run_ok   = (run_len_q != '0) && (run_len_q >= min_len_q);
  assign store_we = cmd_i.take && !is_eos && is_print && (run_len_q < SlotsRun);
  assign emit_cnt = (run_len_q >= SlotsRun) ? SlotsIdx : run_len_q[IW-1:0];

  assign sts_o.emit_req = ends_run && run_ok;
  assign sts_o.rd_last  = (rd_idx_q == last_idx_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  // Position and run tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
    end else if (cmd_i.take) begin
      if (is_eos) begin
        run_len_q  <= '0;
        byte_pos_q <= '0;
      end else begin
        byte_pos_q <= byte_pos_q + PosW'(1);
        if (is_print) begin
          if (run_len_q == '0) begin
            run_start_q <= byte_pos_q;
          end
          if (run_len_q != RunMax) begin
            run_len_q <= run_len_q + RunW'(1);
          end
        end else begin
          run_len_q <= '0;
        end
      end
    end
  end

  // Read pointer: arm on a run end, advance per loaded character
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && ends_run) begin
      rd_idx_q   <= '0;
      last_idx_q <= emit_cnt - IW'(1);
    end else if (cmd_i.load && !sts_o.rd_last) begin
      rd_idx_q <= rd_idx_q + IW'(1);
    end
  end

  // Character buffer (top entry unused)
  psx_ram #(
    .WIDTH (CharW),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (run_len_q[IW-1:0]),
    .wdata_i (in_byte_i[CharW-1:0]),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_char)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_char_q   <= rd_char;
      out_offset_q <= run_start_q;
      out_last_q   <= sts_o.rd_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_offset_o = out_offset_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: hdl/printable_string_extractor_core.sv
// Top level of the printable string extractor.
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         tdata: data_byte; tuser: kind            tvalid/tready
//  m_axis    out        tdata: text_byte, string_offset; tlast   tvalid/tready
//  cfg       in         min_len                                  valid/ready
//
// Data bytes are taken whenever no string is being read out. A byte that ends a
// reportable run starts read-out: each character is read from the buffer RAM, then
// loaded into the output register; the input stays stalled until the last is loaded.
// The output register decouples the sides; the last character may wait while
// the next input beat is taken. Reset is asynchronous and active low; the
// buffer needs no clearing pass. Configuration is always ready.
module printable_string_extractor_core
  import psx_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [KindW-1:0]    s_axis_tuser,   // [0] kind
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [6:0] text_byte, [54:7] string_offset
  output logic                m_axis_tlast,   // last_of_string
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [MinLenW-1:0]  cfg_data_i
);

  psx_cmd_t         cmd;
  psx_sts_t         sts;
  logic [CharW-1:0] out_char;
  logic [PosW-1:0]  out_offset;

  assign cfg_ready_o = 1'b1;

  psx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psx_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_kind_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_offset_o (out_offset),
    .out_last_o   (m_axis_tlast)
  );

  // Pack output beat, zero padding on top
  assign m_axis_tdata = {{(OutDataW - CharW - PosW){1'b0}}, out_offset, out_char};

  // Never overwrite a beat still waiting downstream
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // Only printable characters leave the block
  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_char >= FirstPrintable[CharW-1:0]) &&
                      (out_char <= LastPrintable[CharW-1:0]))
    else $error("non-printable character emitted");

  // Input reopens right after the final character is loaded
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && sts.rd_last) |=> s_axis_tready)
    else $error("input not reopened after string end");

  // Input is never taken during read-out
  a_no_take_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !s_axis_tready)
    else $error("input accepted during read-out");

endmodule
